// File: rtl/core/v3au_pkg.sv
// shared widths, opcode and status codes and stage payload types of the vector unit
package v3au_pkg;

   localparam int CW    = 32;              // component width
   localparam int FB    = 16;              // fraction bits
   localparam int OPW   = 4;               // opcode width
   localparam int STW   = 2;               // status width
   localparam int PW    = 2 * CW;          // full product width
   localparam int SUMW  = PW + 2;          // sum of three products
   localparam int NUMW  = CW + FB;         // scaled dividend width
   localparam int REMW  = CW + 3;          // root partial remainder
   localparam int REQ_W = 7 * CW;
   localparam int RSP_W = ((4 * CW + STW + 7) / 8) * 8;
   localparam int RSP_PAD = RSP_W - 4 * CW - STW;

   typedef enum logic [OPW-1:0] {
      OP_ADD   = 4'd0,
      OP_SUB   = 4'd1,
      OP_SCALE = 4'd2,
      OP_DIV   = 4'd3,
      OP_CROSS = 4'd4,
      OP_DOT   = 4'd5,
      OP_SQLEN = 4'd6,
      OP_LEN   = 4'd7,
      OP_NORM  = 4'd8
   } op_type;

   typedef enum logic [STW-1:0] {
      ST_OK  = 2'd0,
      ST_SAT = 2'd1,
      ST_DZ  = 2'd2
   } status_type;

   // carried alongside the square root pipeline
   typedef struct packed {
      logic [OPW-1:0]       op;
      logic [2:0][CW-1:0]   a;
      logic [CW-1:0]        s;
      logic [2:0][CW-1:0]   r;
      logic [CW-1:0]        sc;
      logic                 sat;
   } sq_meta_type;

   // carried alongside the divider pipeline
   typedef struct packed {
      logic [OPW-1:0]       op;
      logic [2:0][CW-1:0]   r;
      logic [CW-1:0]        sc;
      logic                 sat;
      logic                 dz;
      logic [2:0]           neg;
   } dv_meta_type;

endpackage

// File: rtl/core/v3au_isqrt.sv
// pipelined integer square root, one result bit per stage
module v3au_isqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic [v3au_pkg::PW-1:0] in_rad,
   input  v3au_pkg::sq_meta_type in_meta,
   output logic                  out_valid,
   output logic [v3au_pkg::CW-1:0] out_root,
   output v3au_pkg::sq_meta_type out_meta
);

   localparam int N = v3au_pkg::CW;

   logic                          valid_ff [N];
   logic [v3au_pkg::REMW-1:0]     rem_ff   [N];
   logic [v3au_pkg::CW-1:0]       root_ff  [N];
   logic [v3au_pkg::PW-1:0]       rad_ff   [N];
   v3au_pkg::sq_meta_type         meta_ff  [N];

   logic                          valid_src [N];
   logic [v3au_pkg::REMW-1:0]     rem_src   [N];
   logic [v3au_pkg::CW-1:0]       root_src  [N];
   logic [v3au_pkg::PW-1:0]       rad_src   [N];
   v3au_pkg::sq_meta_type         meta_src  [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [v3au_pkg::REMW-1:0] rem_t;
      logic [v3au_pkg::REMW-1:0] trial;
      logic                      ge;
      logic [v3au_pkg::REMW-1:0] rem_in;
      logic [v3au_pkg::CW-1:0]   root_in;

      if (k == 0) begin : g_first
         assign valid_src[k] = in_valid;
         assign rem_src[k]   = '0;
         assign root_src[k]  = '0;
         assign rad_src[k]   = in_rad;
         assign meta_src[k]  = in_meta;
      end else begin : g_next
         assign valid_src[k] = valid_ff[k-1];
         assign rem_src[k]   = rem_ff[k-1];
         assign root_src[k]  = root_ff[k-1];
         assign rad_src[k]   = rad_ff[k-1];
         assign meta_src[k]  = meta_ff[k-1];
      end

      // bring down the next two radicand bits and try root*4+1
      assign rem_t   = {rem_src[k][v3au_pkg::REMW-3:0], rad_src[k][v3au_pkg::PW-1 -: 2]};
      assign trial   = {1'b0, root_src[k], 2'b01};
      assign ge      = (rem_t >= trial);
      assign rem_in  = ge ? (rem_t - trial) : rem_t;
      assign root_in = {root_src[k][v3au_pkg::CW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_src[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= {rad_src[k][v3au_pkg::PW-3:0], 2'b00};
            meta_ff[k] <= meta_src[k];
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_meta  = meta_ff[N-1];

endmodule

// File: rtl/core/v3au_divider.sv
// three-lane pipelined restoring divider, one quotient bit per stage
module v3au_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  logic [2:0][v3au_pkg::NUMW-1:0]    in_num,
   input  logic [v3au_pkg::CW-1:0]           in_den,
   input  v3au_pkg::dv_meta_type             in_meta,
   output logic                              out_valid,
   output logic [2:0][v3au_pkg::NUMW-1:0]    out_quo,
   output v3au_pkg::dv_meta_type             out_meta
);

   localparam int N = v3au_pkg::NUMW;
   localparam int W = v3au_pkg::CW;

   logic                         valid_ff [N];
   logic [2:0][W-1:0]            rem_ff   [N];
   logic [2:0][N-1:0]            nq_ff    [N];
   logic [W-1:0]                 den_ff   [N];
   v3au_pkg::dv_meta_type        meta_ff  [N];

   logic                         valid_src [N];
   logic [2:0][W-1:0]            rem_src   [N];
   logic [2:0][N-1:0]            nq_src    [N];
   logic [W-1:0]                 den_src   [N];
   v3au_pkg::dv_meta_type        meta_src  [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [2:0][W-1:0] rem_in;
      logic [2:0][N-1:0] nq_in;

      if (k == 0) begin : g_first
         assign valid_src[k] = in_valid;
         assign rem_src[k]   = '0;
         assign nq_src[k]    = in_num;
         assign den_src[k]   = in_den;
         assign meta_src[k]  = in_meta;
      end else begin : g_next
         assign valid_src[k] = valid_ff[k-1];
         assign rem_src[k]   = rem_ff[k-1];
         assign nq_src[k]    = nq_ff[k-1];
         assign den_src[k]   = den_ff[k-1];
         assign meta_src[k]  = meta_ff[k-1];
      end

      // dividend bits leave at the top while quotient bits enter at the bottom
      always_comb begin
         logic [W:0] rem_t;
         logic [W:0] diff;
         logic       ge;
         for (int j = 0; j < 3; j++) begin
            rem_t     = {rem_src[k][j], nq_src[k][j][N-1]};
            diff      = rem_t - {1'b0, den_src[k]};
            ge        = (rem_t >= {1'b0, den_src[k]});
            rem_in[j] = ge ? diff[W-1:0] : rem_t[W-1:0];
            nq_in[j]  = {nq_src[k][j][N-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_src[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            nq_ff[k]   <= nq_in;
            den_ff[k]  <= den_src[k];
            meta_ff[k] <= meta_src[k];
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_quo   = nq_ff[N-1];
   assign out_meta  = meta_ff[N-1];

endmodule

// File: rtl/core/vector3_arith_unit_core.sv
// top level of the fixed-point 3d vector unit
// Fixed-point Q16.16 3d vector unit: add, subtract, scale, divide, cross, dot,
// squared length, length and normalize. One transaction is taken every cycle
// while the result side is not stalled, and each gives exactly one result; most
// of the depth comes from the bit-per-stage square root (32 stages) and the
// bit-per-stage divider (48 stages, three lanes), which every op passes through
// so results stay in order. A stall on the result side holds the whole pipeline.
// Overflow clamps and reports status 1; divide by zero or normalizing a zero
// vector gives zeros and status 2; unused opcodes give zeros and status 0.
module vector3_arith_unit_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, scalar_in
   input  logic [v3au_pkg::REQ_W-1:0]    req_tdata,
   // op
   input  logic [v3au_pkg::OPW-1:0]      req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // r_x, r_y, r_z, scalar_out, status, zero padding
   output logic [v3au_pkg::RSP_W-1:0]    rsp_tdata
);

   localparam int CW   = v3au_pkg::CW;
   localparam int FB   = v3au_pkg::FB;
   localparam int PW   = v3au_pkg::PW;
   localparam int SUMW = v3au_pkg::SUMW;
   localparam int NUMW = v3au_pkg::NUMW;

   localparam logic signed [SUMW-1:0] SAT_MAX = {{(SUMW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [SUMW-1:0] SAT_MIN = {{(SUMW-CW+1){1'b1}}, {(CW-1){1'b0}}};

   // {sat, value}
   function automatic logic [CW:0] clamp_fn(input logic signed [SUMW-1:0] v);
      logic [CW:0] res;
      if (v > SAT_MAX) begin
         res = {1'b1, SAT_MAX[CW-1:0]};
      end else if (v < SAT_MIN) begin
         res = {1'b1, SAT_MIN[CW-1:0]};
      end else begin
         res = {1'b0, v[CW-1:0]};
      end
      return res;
   endfunction

   logic adv;

   // stage 0: input registers
   logic                        v0_ff;
   logic [v3au_pkg::OPW-1:0]    op0_ff;
   logic signed [CW-1:0]        a0_ff [3];
   logic signed [CW-1:0]        b0_ff [3];
   logic signed [CW-1:0]        s0_ff;

   // stage 1: products
   logic                        v1_ff;
   logic [v3au_pkg::OPW-1:0]    op1_ff;
   logic signed [CW-1:0]        a1_ff [3];
   logic signed [CW-1:0]        s1_ff;
   logic signed [PW-1:0]        p1_ff [6];
   logic signed [CW:0]          as1_ff [3];
   logic signed [CW-1:0]        m1 [6];
   logic signed [CW-1:0]        m2 [6];
   logic signed [PW-1:0]        p1_in [6];
   logic signed [CW:0]          as1_in [3];

   // stage 2: sums and scaling
   logic                        v2_ff;
   logic [v3au_pkg::OPW-1:0]    op2_ff;
   logic signed [CW-1:0]        a2_ff [3];
   logic signed [CW-1:0]        s2_ff;
   logic signed [SUMW-1:0]      t2_ff [3];
   logic [PW-1:0]               sq2_ff;
   logic signed [SUMW-1:0]      t2_in [3];
   logic signed [SUMW-1:0]      sum2;

   // square root
   v3au_pkg::sq_meta_type       sq_meta_in;
   logic                        sq_out_valid;
   logic [CW-1:0]               sq_root;
   v3au_pkg::sq_meta_type       sq_meta;

   // divider set-up stage
   logic                        d0_valid_ff;
   logic [2:0][NUMW-1:0]        d0_num_ff;
   logic [CW-1:0]               d0_den_ff;
   v3au_pkg::dv_meta_type       d0_meta_ff;
   logic [2:0][NUMW-1:0]        d0_num_in;
   logic [CW-1:0]               d0_den_in;
   v3au_pkg::dv_meta_type       d0_meta_in;

   logic                        dv_out_valid;
   logic [2:0][NUMW-1:0]        dv_quo;
   v3au_pkg::dv_meta_type       dv_meta;

   // output register
   logic                        rsp_valid_ff;
   logic [2:0][CW-1:0]          rsp_r_ff;
   logic [CW-1:0]               rsp_sc_ff;
   logic [v3au_pkg::STW-1:0]    rsp_st_ff;
   logic [2:0][CW-1:0]          rsp_r_in;
   logic [CW-1:0]               rsp_sc_in;
   logic [v3au_pkg::STW-1:0]    rsp_st_in;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // ---------------- stage 0
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op0_ff <= req_tuser;
         s0_ff  <= req_tdata[6*CW +: CW];
         for (int i = 0; i < 3; i++) begin
            a0_ff[i] <= req_tdata[i*CW +: CW];
            b0_ff[i] <= req_tdata[(3+i)*CW +: CW];
         end
      end
   end

   // ---------------- stage 1: operand routing into six multipliers
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         m1[k] = '0;
         m2[k] = '0;
      end
      case (op0_ff)
         v3au_pkg::OP_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               m1[i] = a0_ff[i];
               m2[i] = s0_ff;
            end
         end
         v3au_pkg::OP_CROSS: begin
            m1[0] = a0_ff[1]; m2[0] = b0_ff[2];
            m1[1] = a0_ff[2]; m2[1] = b0_ff[1];
            m1[2] = a0_ff[2]; m2[2] = b0_ff[0];
            m1[3] = a0_ff[0]; m2[3] = b0_ff[2];
            m1[4] = a0_ff[0]; m2[4] = b0_ff[1];
            m1[5] = a0_ff[1]; m2[5] = b0_ff[0];
         end
         v3au_pkg::OP_DOT: begin
            for (int i = 0; i < 3; i++) begin
               m1[i] = a0_ff[i];
               m2[i] = b0_ff[i];
            end
         end
         v3au_pkg::OP_SQLEN, v3au_pkg::OP_LEN, v3au_pkg::OP_NORM: begin
            for (int i = 0; i < 3; i++) begin
               m1[i] = a0_ff[i];
               m2[i] = a0_ff[i];
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         p1_in[k] = m1[k] * m2[k];
      end
      for (int i = 0; i < 3; i++) begin
         if (op0_ff == v3au_pkg::OP_SUB) begin
            as1_in[i] = (CW+1)'(a0_ff[i]) - (CW+1)'(b0_ff[i]);
         end else begin
            as1_in[i] = (CW+1)'(a0_ff[i]) + (CW+1)'(b0_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op1_ff <= op0_ff;
         s1_ff  <= s0_ff;
         for (int i = 0; i < 3; i++) begin
            a1_ff[i]  <= a0_ff[i];
            as1_ff[i] <= as1_in[i];
         end
         for (int k = 0; k < 6; k++) begin
            p1_ff[k] <= p1_in[k];
         end
      end
   end

   // ---------------- stage 2: exact sums, floor shift by the fraction bits
   assign sum2 = SUMW'(p1_ff[0]) + SUMW'(p1_ff[1]) + SUMW'(p1_ff[2]);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         t2_in[i] = '0;
      end
      case (op1_ff)
         v3au_pkg::OP_ADD, v3au_pkg::OP_SUB: begin
            for (int i = 0; i < 3; i++) begin
               t2_in[i] = SUMW'(as1_ff[i]);
            end
         end
         v3au_pkg::OP_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               t2_in[i] = SUMW'(p1_ff[i]) >>> FB;
            end
         end
         v3au_pkg::OP_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               t2_in[i] = (SUMW'(p1_ff[2*i]) - SUMW'(p1_ff[2*i+1])) >>> FB;
            end
         end
         v3au_pkg::OP_DOT, v3au_pkg::OP_SQLEN: begin
            t2_in[0] = sum2 >>> FB;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op2_ff <= op1_ff;
         s2_ff  <= s1_ff;
         sq2_ff <= sum2[PW-1:0];
         for (int i = 0; i < 3; i++) begin
            a2_ff[i] <= a1_ff[i];
            t2_ff[i] <= t2_in[i];
         end
      end
   end

   // ---------------- clamp of the arithmetic results, then into the root pipeline
   always_comb begin
      logic [CW:0] c [3];
      for (int i = 0; i < 3; i++) begin
         c[i] = clamp_fn(t2_ff[i]);
      end
      sq_meta_in.op  = op2_ff;
      sq_meta_in.s   = s2_ff;
      sq_meta_in.r   = '0;
      sq_meta_in.sc  = '0;
      sq_meta_in.sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         sq_meta_in.a[i] = a2_ff[i];
      end
      case (op2_ff)
         v3au_pkg::OP_ADD, v3au_pkg::OP_SUB, v3au_pkg::OP_SCALE, v3au_pkg::OP_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               sq_meta_in.r[i] = c[i][CW-1:0];
            end
            sq_meta_in.sat = c[0][CW] | c[1][CW] | c[2][CW];
         end
         v3au_pkg::OP_DOT, v3au_pkg::OP_SQLEN: begin
            sq_meta_in.sc  = c[0][CW-1:0];
            sq_meta_in.sat = c[0][CW];
         end
         default: begin
         end
      endcase
   end

   v3au_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v2_ff),
      .in_rad    (sq2_ff),
      .in_meta   (sq_meta_in),
      .out_valid (sq_out_valid),
      .out_root  (sq_root),
      .out_meta  (sq_meta)
   );

   // ---------------- divider set-up: magnitudes, signs, divisor choice
   always_comb begin
      logic          is_div;
      logic [CW-1:0] s_abs;
      logic [CW-1:0] a_abs;
      is_div = (sq_meta.op == v3au_pkg::OP_DIV);
      s_abs  = sq_meta.s[CW-1] ? (CW)'(-sq_meta.s) : sq_meta.s;
      d0_den_in = is_div ? s_abs : sq_root;

      d0_meta_in.op  = sq_meta.op;
      d0_meta_in.r   = sq_meta.r;
      d0_meta_in.sc  = sq_meta.sc;
      d0_meta_in.sat = sq_meta.sat;
      d0_meta_in.dz  = (is_div && (sq_meta.s == '0)) ||
                       ((sq_meta.op == v3au_pkg::OP_NORM) && (sq_root == '0));
      for (int i = 0; i < 3; i++) begin
         a_abs = sq_meta.a[i][CW-1] ? (CW)'(-sq_meta.a[i]) : sq_meta.a[i];
         d0_num_in[i] = {a_abs, {FB{1'b0}}};
         d0_meta_in.neg[i] = sq_meta.a[i][CW-1] ^ (is_div && sq_meta.s[CW-1]);
      end
      // length saturates once the root reaches the sign bit
      if (sq_meta.op == v3au_pkg::OP_LEN) begin
         d0_meta_in.sat = sq_root[CW-1];
         d0_meta_in.sc  = sq_root[CW-1] ? SAT_MAX[CW-1:0] : sq_root;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d0_valid_ff <= 1'b0;
      end else if (adv) begin
         d0_valid_ff <= sq_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d0_num_ff  <= d0_num_in;
         d0_den_ff  <= d0_den_in;
         d0_meta_ff <= d0_meta_in;
      end
   end

   v3au_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (d0_valid_ff),
      .in_num    (d0_num_ff),
      .in_den    (d0_den_ff),
      .in_meta   (d0_meta_ff),
      .out_valid (dv_out_valid),
      .out_quo   (dv_quo),
      .out_meta  (dv_meta)
   );

   // ---------------- result selection
   always_comb begin
      logic signed [SUMW-1:0] qv;
      logic [CW:0]            dq [3];
      logic                   dsat;
      dsat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         qv    = {{(SUMW-NUMW){1'b0}}, dv_quo[i]};
         dq[i] = clamp_fn(dv_meta.neg[i] ? -qv : qv);
         dsat  = dsat | dq[i][CW];
      end
      rsp_r_in  = '0;
      rsp_sc_in = '0;
      rsp_st_in = v3au_pkg::ST_OK;
      case (dv_meta.op)
         v3au_pkg::OP_ADD, v3au_pkg::OP_SUB, v3au_pkg::OP_SCALE, v3au_pkg::OP_CROSS: begin
            rsp_r_in  = dv_meta.r;
            rsp_st_in = dv_meta.sat ? v3au_pkg::ST_SAT : v3au_pkg::ST_OK;
         end
         v3au_pkg::OP_DIV, v3au_pkg::OP_NORM: begin
            if (dv_meta.dz) begin
               rsp_st_in = v3au_pkg::ST_DZ;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  rsp_r_in[i] = dq[i][CW-1:0];
               end
               rsp_st_in = dsat ? v3au_pkg::ST_SAT : v3au_pkg::ST_OK;
            end
         end
         v3au_pkg::OP_DOT, v3au_pkg::OP_SQLEN, v3au_pkg::OP_LEN: begin
            rsp_sc_in = dv_meta.sc;
            rsp_st_in = dv_meta.sat ? v3au_pkg::ST_SAT : v3au_pkg::ST_OK;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_r_ff  <= rsp_r_in;
         rsp_sc_ff <= rsp_sc_in;
         rsp_st_ff <= rsp_st_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{v3au_pkg::RSP_PAD{1'b0}}, rsp_st_ff, rsp_sc_ff,
                        rsp_r_ff[2], rsp_r_ff[1], rsp_r_ff[0]};

   // ---------------- assertions
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_st_ff == v3au_pkg::ST_DZ)) |->
         ((rsp_r_ff == '0) && (rsp_sc_ff == '0)))
      else $error("divide-by-zero result carries non-zero data");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=>
         ($stable(dv_out_valid) && $stable(dv_quo) && $stable(d0_valid_ff)))
      else $error("pipeline moved while the result was stalled");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("result valid straight after reset");

endmodule
